>>> sv/wmbs_pkg.sv
// Shared types and constants for the waveform median baseline block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package wmbs_pkg;

    localparam int IN_SAMPLE_W  = 14;
    localparam int CHANNEL_W    = 10;
    localparam int LEVEL_W      = 15;
    localparam int TALLY_W      = 10;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 10'd1023;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 56;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // store the input beat
        logic init;          // set up rank and prefix, start the first bit pass
        logic start_bit;     // start the next bit pass
        logic commit_bit;    // decide the current bit
        logic start_final;   // start the neighbor pass
        logic commit_final;  // form the baseline
        logic load_out;      // load the result register, clear the waveform
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic bits_done;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/wmbs_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module wmbs_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/wmbs_ctrl.sv
// Controller for the waveform median baseline block: sequences collection,
// bitwise rank selection passes and result hand-off. Depends on wmbs_pkg.
`default_nettype none
module wmbs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    input  wire wmbs_pkg::dp_stat_t  stat,
    output wmbs_pkg::dp_cmd_t        cmd
);
    import wmbs_pkg::*;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_SCAN_BIT,
        S_NEXT,
        S_SCAN_FIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_COLLECT:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_last)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_SCAN_BIT;
                end
            end
            S_SCAN_BIT:
            begin
                if (stat.scan_done)
                begin
                    cmd.commit_bit = 1'b1;
                    state_next     = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (stat.bits_done)
                begin
                    cmd.start_final = 1'b1;
                    state_next      = S_SCAN_FIN;
                end
                else
                begin
                    cmd.start_bit = 1'b1;
                    state_next    = S_SCAN_BIT;
                end
            end
            S_SCAN_FIN:
            begin
                if (stat.scan_done)
                begin
                    cmd.commit_final = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/wmbs_dp.sv
// Datapath for the waveform median baseline block: sample store, running
// minimum, rank selection counters and result register. Depends on wmbs_pkg, wmbs_ram.
`default_nettype none
module wmbs_dp #(
    parameter int MAX_SAMPLES = 8192,
    parameter int SAMPLE_BITS = 14
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire wmbs_pkg::dp_cmd_t                cmd,
    output wmbs_pkg::dp_stat_t                    stat,
    input  wire logic [wmbs_pkg::IN_SAMPLE_W-1:0] in_sample,
    input  wire logic [wmbs_pkg::CHANNEL_W-1:0]   in_channel,
    input  wire logic                             in_event_last,
    input  wire logic [wmbs_pkg::LEVEL_W-1:0]     level,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic      [wmbs_pkg::CHANNEL_W-1:0]   out_channel,
    output logic      [wmbs_pkg::IN_SAMPLE_W-1:0] out_baseline,
    output logic      [wmbs_pkg::IN_SAMPLE_W-1:0] out_minimum,
    output logic                                  out_saturated,
    output logic      [wmbs_pkg::TALLY_W-1:0]     out_count,
    output logic                                  out_done
);
    import wmbs_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int BW = (SB > 1) ? $clog2(SB) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_SAMPLES);

    logic [CW-1:0] cnt_reg, idx_reg, acc_reg, rank_reg, k_reg;
    logic [SB-1:0] min_reg, prefix_reg, min_gt_reg, base_reg;
    logic [BW-1:0] bit_reg;
    logic          bits_done_reg, active_reg, final_reg, rd_vld_reg, ev_last_reg;
    logic [CHANNEL_W-1:0] chan_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic                 out_valid_reg;

    logic [SB-1:0] s_in, rdata, himask;
    logic          store_we, re, match;
    logic [CW-1:0] cnt_new;
    logic [CW-1:0] k_init;
    logic [SB-1:0] hi_val;
    logic [SB:0]   pair_sum;
    logic          sat;
    logic [TALLY_W-1:0] tally_next;

    assign s_in     = SB'(in_sample);
    assign store_we = cmd.accept && (cnt_reg < FULL);
    assign re       = active_reg && (idx_reg < cnt_reg);
    assign himask   = {SB{1'b1}} << bit_reg;
    assign match    = ((rdata ^ prefix_reg) & himask) == '0;
    // Count including the closing beat, which is stored in the same cycle if there is room.
    assign cnt_new  = store_we ? CW'(cnt_reg + 1'b1) : cnt_reg;
    assign k_init   = cnt_new[0] ? (cnt_new >> 1) : CW'((cnt_new >> 1) - 1'b1);
    assign hi_val   = ((CW + 1)'(acc_reg) > (CW + 1)'(k_reg) + 1'b1) ? prefix_reg
                                                                     : min_gt_reg;
    assign pair_sum = (SB + 1)'(prefix_reg) + (SB + 1)'(hi_val);
    assign sat      = 17'(min_reg) < 17'(level);
    assign tally_next = (sat && tally_reg != TALLY_MAX) ? tally_reg + 1'b1 : tally_reg;

    assign stat.scan_done = active_reg && (idx_reg >= cnt_reg) && !rd_vld_reg;
    assign stat.bits_done = bits_done_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;

    wmbs_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_in),
        .re    (re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_reg       <= '1;
            chan_reg      <= '0;
            tally_reg     <= '0;
            active_reg    <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= re;
            if (re)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                if (cnt_reg == '0)
                begin
                    chan_reg <= in_channel;
                end
                if (store_we)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (s_in < min_reg)
                    begin
                        min_reg <= s_in;
                    end
                end
                ev_last_reg <= in_event_last;
            end
            if (cmd.init || cmd.start_bit || cmd.start_final)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
                acc_reg    <= '0;
                min_gt_reg <= '1;
                final_reg  <= cmd.start_final;
            end
            if (cmd.init)
            begin
                rank_reg      <= k_init;
                k_reg         <= k_init;
                prefix_reg    <= '0;
                bit_reg       <= BW'(SB - 1);
                bits_done_reg <= 1'b0;
            end
            // Bit pass: count matches; final pass: count <= prefix, keep least above.
            if (rd_vld_reg)
            begin
                if (!final_reg)
                begin
                    if (match)
                    begin
                        acc_reg <= acc_reg + 1'b1;
                    end
                end
                else if (rdata <= prefix_reg)
                begin
                    acc_reg <= acc_reg + 1'b1;
                end
                else if (rdata < min_gt_reg)
                begin
                    min_gt_reg <= rdata;
                end
            end
            if (cmd.commit_bit)
            begin
                active_reg <= 1'b0;
                if (rank_reg >= acc_reg)
                begin
                    prefix_reg[bit_reg] <= 1'b1;
                    rank_reg            <= rank_reg - acc_reg;
                end
                if (bit_reg == '0)
                begin
                    bits_done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
            if (cmd.commit_final)
            begin
                active_reg <= 1'b0;
                base_reg   <= cnt_reg[0] ? prefix_reg : pair_sum[SB:1];
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                out_channel   <= chan_reg;
                out_baseline  <= IN_SAMPLE_W'(base_reg);
                out_minimum   <= IN_SAMPLE_W'(min_reg);
                out_saturated <= sat;
                out_count     <= tally_next;
                out_done      <= ev_last_reg;
                tally_reg     <= ev_last_reg ? '0 : tally_next;
                cnt_reg       <= '0;
                min_reg       <= '1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/waveform_median_baseline_saturation.sv
// Top level of the waveform median baseline and saturation check.
// Depends on wmbs_pkg, wmbs_ctrl, wmbs_dp (which holds wmbs_ram).
//
//  channel  dir  tdata fields (low bit up)                     tlast       tuser
//  s_axis   in   sample[13:0], channel_id[23:14]               last_sample last_of_event
//  m_axis   out  out_channel, baseline, minimum, saturated,    event_done  -
//                event_saturated_count (49 bits, zero padded)
//  cfg      in   cfg_wdata = saturation_level, written on cfg_we
//
// While collecting, each sample beat is stored as it arrives if the store has room.
// The closing beat starts SAMPLE_BITS bit passes plus one neighbor pass over the
// store, each reading the stored samples through the single read port of the RAM.
// Input is held off during the passes and taken again once the result is loaded;
// it stays held off longer while an older result still waits. Reset is asynchronous
// and needs no clearing pass. A stalled result holds in the output register while
// the next waveform loads.
`default_nettype none
module waveform_median_baseline_saturation #(
    parameter int MAX_SAMPLES = 8192,
    parameter int SAMPLE_BITS = 14
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [wmbs_pkg::S_TDATA_W-1:0]     s_tdata,  // sample, channel_id
    input  wire logic                               s_tlast,
    input  wire logic                               s_tuser,  // last_of_event
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_channel, baseline, minimum, saturated, event_saturated_count
    output logic      [wmbs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                    m_tlast,  // event_done
    input  wire logic                               cfg_we,
    input  wire logic [wmbs_pkg::LEVEL_W-1:0]       cfg_wdata
);
    import wmbs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [LEVEL_W-1:0]     level_reg;
    logic [CHANNEL_W-1:0]   o_channel;
    logic [IN_SAMPLE_W-1:0] o_baseline, o_minimum;
    logic                   o_saturated;
    logic [TALLY_W-1:0]     o_count;

    // Hold the saturation level between writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cfg_we)
        begin
            level_reg <= cfg_wdata;
        end
    end

    wmbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wmbs_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_sample     (s_tdata[13:0]),
        .in_channel    (s_tdata[23:14]),
        .in_event_last (s_tuser),
        .level         (level_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_channel   (o_channel),
        .out_baseline  (o_baseline),
        .out_minimum   (o_minimum),
        .out_saturated (o_saturated),
        .out_count     (o_count),
        .out_done      (m_tlast)
    );

    assign m_tdata = {7'd0, o_count, o_saturated, o_minimum, o_baseline, o_channel};

    // The median can never lie below the minimum.
    a_base_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:10] >= m_tdata[37:24]))
        else $error("baseline below minimum");

    // A new result only appears while input is held off.
    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(!s_tready))
        else $error("result loaded while collecting");

    // A saturated count of zero cannot go with a saturated waveform.
    a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[38]) |-> (m_tdata[48:39] != 10'd0))
        else $error("saturated waveform not counted");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for waveform_median_baseline_saturation.
// Depends on wmbs_pkg and the block's RTL. A queue-fed driver and a clocked
// monitor check every result beat against a built-in median/minimum predictor.
`default_nettype none
module tb_top;
    import wmbs_pkg::*;

    localparam int MAX_SAMPLES = 8192;
    localparam int SAMPLE_MASK = 16'h3FFF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct {
        logic [13:0] sample;
        logic [9:0]  channel;
        logic        last_sample;
        logic        last_of_event;
    } sample_beat_t;

    typedef struct {
        logic [9:0]  channel;
        logic [13:0] baseline;
        logic [13:0] minimum;
        logic        saturated;
        logic [9:0]  sat_count;
        logic        event_done;
    } wave_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // sample[13:0], channel_id[23:14]
    logic s_tlast;                   // last_sample
    logic s_tuser;                   // last_of_event
    logic m_tvalid;
    logic m_tready;
    // out_channel[9:0], baseline[23:10], minimum[37:24], saturated[38],
    // event_saturated_count[48:39], zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;                   // event_done
    logic cfg_we;
    logic [LEVEL_W-1:0] cfg_wdata;

    waveform_median_baseline_saturation #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(14)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Stimulus waiting to be offered and results waiting to arrive.
    sample_beat_t beat_fifo[$];
    wave_result_t result_fifo[$];

    // Predictor state: the waveform being collected and the event tally.
    int unsigned wave_samples[$];
    int unsigned wave_min;
    logic [9:0]  wave_channel;
    int unsigned sat_tally;
    int unsigned sat_level;

    int unsigned errors;
    int unsigned waves_seen;
    int unsigned sat_seen;
    int unsigned events_seen;
    int unsigned idle_cycles;
    bit          no_idle;       // suppress random idling on both sides
    bit          rx_hold_req;   // ask the receiver for one long hold-off
    bit          rx_hold_done;
    int unsigned rx_hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Median of the collected waveform: sort a copy, average the middle pair
    // (floored) when the count is even.
    function automatic int unsigned median_of_wave();
        int unsigned sorted[];
        int unsigned n;
        n = wave_samples.size();
        sorted = new[n];
        foreach (wave_samples[i]) sorted[i] = wave_samples[i];
        sorted.sort();
        if (n[0] == 1'b0)
            return (sorted[n / 2 - 1] + sorted[n / 2]) >> 1;
        return sorted[n / 2];
    endfunction

    // Fold one accepted beat into the predictor; close the waveform on
    // last_sample and queue the result it causes.
    task automatic predict_beat(input sample_beat_t b);
        wave_result_t r;
        if (wave_samples.size() == 0)
            wave_channel = b.channel;
        // Drop samples once the store is full.
        if (wave_samples.size() < MAX_SAMPLES)
        begin
            wave_samples.insert(wave_samples.size(), 32'(b.sample));
            if (b.sample < wave_min)
                wave_min = b.sample;
        end
        if (b.last_sample)
        begin
            r.channel   = wave_channel;
            r.baseline  = 14'(median_of_wave());
            r.minimum   = 14'(wave_min);
            r.saturated = (wave_min < sat_level);
            if (r.saturated && sat_tally < 1023)
                sat_tally++;
            r.sat_count  = 10'(sat_tally);
            r.event_done = b.last_of_event;
            result_fifo.insert(result_fifo.size(), r);
            wave_samples.delete();
            wave_min = SAMPLE_MASK;
            if (b.last_of_event)
                sat_tally = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want,
                 waves_seen);
    endtask

    // Driver: retire the accepted beat, then hold, offer the next or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_beat(beat_fifo.pop_front());
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the beat until it is taken
            end
            else if (beat_fifo.size() > 0 && (no_idle || $urandom_range(99) >= 23))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {beat_fifo[0].channel, beat_fifo[0].sample};
                s_tlast  <= beat_fifo[0].last_sample;
                s_tuser  <= beat_fifo[0].last_of_event;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_req && !rx_hold_done)
            begin
                rx_hold_done <= 1'b1;
                rx_hold_left <= 3000;
                m_tready     <= 1'b0;
            end
            else if (rx_hold_left > 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end
            else
            begin
                m_tready <= no_idle || ($urandom_range(99) >= 23);
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        wave_result_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_fifo.size() == 0)
            begin
                errors++;
                $display("unexpected result beat, tdata %h", m_tdata);
            end
            else
            begin
                w = result_fifo.pop_front();
                if (m_tdata[9:0] !== w.channel)
                    report_mismatch("out_channel", 32'(m_tdata[9:0]), 32'(w.channel));
                if (m_tdata[23:10] !== w.baseline)
                    report_mismatch("baseline", 32'(m_tdata[23:10]), 32'(w.baseline));
                if (m_tdata[37:24] !== w.minimum)
                    report_mismatch("minimum", 32'(m_tdata[37:24]), 32'(w.minimum));
                if (m_tdata[38] !== w.saturated)
                    report_mismatch("saturated", 32'(m_tdata[38]), 32'(w.saturated));
                if (m_tdata[48:39] !== w.sat_count)
                    report_mismatch("event_saturated_count", 32'(m_tdata[48:39]),
                                    32'(w.sat_count));
                if (m_tlast !== w.event_done)
                    report_mismatch("event_done", 32'(m_tlast), 32'(w.event_done));
            end
            waves_seen++;
            if (m_tdata[38])
                sat_seen++;
            if (m_tlast)
                events_seen++;
        end
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Queue one waveform; samples uniform in [lo, hi]. A sample other than the
    // last may carry a stray event mark when noisy is set.
    task automatic queue_wave(input int unsigned n, input int unsigned lo,
                              input int unsigned hi, input logic [9:0] ch,
                              input logic ev, input bit noisy);
        sample_beat_t b;
        for (int unsigned i = 0; i < n; i++)
        begin
            b.sample        = 14'($urandom_range(hi, lo));
            b.channel       = (noisy && i > 0) ? 10'($urandom) : ch;
            b.last_sample   = (i == n - 1);
            b.last_of_event = (i == n - 1) ? ev : (noisy && $urandom_range(3) == 0);
            beat_fifo.insert(beat_fifo.size(), b);
        end
    endtask

    task automatic queue_fixed(input int unsigned s, input logic [9:0] ch,
                               input logic last, input logic ev);
        sample_beat_t b;
        b.sample        = 14'(s);
        b.channel       = ch;
        b.last_sample   = last;
        b.last_of_event = ev;
        beat_fifo.insert(beat_fifo.size(), b);
    endtask

    // Wait until everything queued has been taken and answered, then let the
    // block settle before touching the register.
    task automatic wait_drained();
        while (beat_fifo.size() > 0 || s_tvalid || result_fifo.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_level(input int unsigned v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= LEVEL_W'(v);
        sat_level  = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        wave_min  = SAMPLE_MASK;
        sat_tally = 0;
        sat_level = 0;
        errors = 0; waves_seen = 0; sat_seen = 0; events_seen = 0;
        idle_cycles = 0;
        no_idle = 1'b0; rx_hold_req = 1'b0; rx_hold_done = 1'b0; rx_hold_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset level 0 never saturates, even at sample 0.
        queue_fixed(0, 10'h000, 1'b1, 1'b0);
        queue_fixed(16383, 10'h3FF, 1'b1, 1'b1);
        // Even count: floor of the mean of the middle pair.
        queue_fixed(0, 10'h155, 1'b0, 1'b0);
        queue_fixed(16383, 10'h2AA, 1'b1, 1'b0);
        // Event mark without waveform end is ignored; channel from first beat.
        queue_fixed(7, 10'h012, 1'b0, 1'b1);
        queue_fixed(3, 10'h345, 1'b0, 1'b0);
        queue_fixed(9, 10'h001, 1'b1, 1'b1);
        wait_drained();

        // Minimum equal to the level is not saturated; one below is.
        set_level(100);
        queue_fixed(100, 10'h0AA, 1'b1, 1'b0);
        queue_fixed(99, 10'h0AB, 1'b1, 1'b0);
        queue_fixed(200, 10'h0AC, 1'b0, 1'b0);
        queue_fixed(101, 10'h0AC, 1'b0, 1'b0);
        queue_fixed(0, 10'h0AC, 1'b1, 1'b1);
        wait_drained();

        // A level above every sample saturates everything, the largest sample included.
        set_level(16384);
        queue_fixed(16383, 10'h3FF, 1'b1, 1'b0);
        wait_drained();

        // Tally overflow: more than 1023 saturated waveforms in one event.
        no_idle = 1'b1;
        for (int i = 0; i < 1030; i++)
            queue_fixed($urandom_range(16383), 10'($urandom), 1'b1, i == 1029);
        queue_fixed(5, 10'h111, 1'b1, 1'b1);
        wait_drained();
        no_idle = 1'b0;

        // Random phases over several levels; long receiver hold-off in the first.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_level($urandom_range(16384));
                1: set_level(0);
                2: set_level(32767);
                default: set_level($urandom_range(12000, 4000));
            endcase
            if (phase == 0)
                rx_hold_req = 1'b1;
            if (phase == 2)
                no_idle = 1'b1;
            while (beat_fifo.size() < 170)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 13)
                                             : $urandom_range(12, 1);
                if ($urandom_range(1))
                begin
                    lo = 0;
                    hi = 16383;
                end
                else
                begin
                    lo = $urandom_range(16000);
                    hi = lo + $urandom_range(383);
                end
                queue_wave(n, lo, hi, 10'($urandom), $urandom_range(3) == 0,
                           $urandom_range(4) == 0);
            end
            wait_drained();
            no_idle = 1'b0;
        end

        $display("covered %0d waveform results, %0d saturated, %0d events closed",
                 waves_seen, sat_seen, events_seen);
        $display("levels swept from 0 to the 15-bit maximum, tally limit included");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
